// ===== rtl/sasd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared constants and elaboration-time functions for the actuator step
// delta block: arctangent table, degree-to-radian factor, pipeline depths.
// ----------------------------------------------------------------------------
package sasd_pkg;

  localparam int AngleFracBitsDef = 16;
  localparam int TanIterationsDef = 20;

  localparam int AngleW  = 23;
  localparam int StepW   = 32;
  localparam int DeltaW  = 36;
  localparam int ScaleW  = 20;
  localparam int TanW    = 33;   // signed Q30 tangent
  localparam int QuoBits = 32;   // divider quotient bits

  localparam logic [ScaleW-1:0] ScaleReset = 20'd102160;
  localparam logic [19:0]       K866Q20    = 20'd908093;

  localparam longint unsigned OneQ60 = 64'd1 << 60;

  // n over d, restoring shift and subtract, one quotient bit per pass
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60, i >= 1, by the alternating series
  function automatic longint unsigned atan_pow2_q60(int i);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned t;
    term = OneQ60 >> i;
    sum  = term;
    for (int k = 1; k < 64; k++) begin
      if (2 * i >= 64) break;
      term = term >> (2 * i);
      if (term == 0) break;
      t = udiv64(term, 64'(2 * k + 1));
      sum = ((k & 1) == 1) ? sum - t : sum + t;
    end
    return sum;
  endfunction

  // atan(1/3) in Q60
  function automatic longint unsigned atan_third_q60();
    longint unsigned term;
    longint unsigned sum;
    longint unsigned t;
    term = udiv64(OneQ60, 64'd3);
    sum  = term;
    for (int k = 1; k < 64; k++) begin
      term = udiv64(term, 64'd9);
      if (term == 0) break;
      t = udiv64(term, 64'(2 * k + 1));
      sum = ((k & 1) == 1) ? sum - t : sum + t;
    end
    return sum;
  endfunction

  function automatic longint unsigned quarter_pi_q60();
    return atan_pow2_q60(1) + atan_third_q60();
  endfunction

  // CORDIC angle table entry in Q40
  function automatic logic [40:0] atan_q40(int i);
    longint unsigned v;
    v = (i == 0) ? quarter_pi_q60() : atan_pow2_q60(i);
    v = (v + (64'd1 << 19)) >> 20;
    return v[40:0];
  endfunction

  // pi/180 in Q40
  function automatic logic [34:0] deg2rad_q40();
    longint unsigned v;
    v = (udiv64(quarter_pi_q60(), 64'd45) + (64'd1 << 19)) >> 20;
    return v[34:0];
  endfunction

  function automatic int cordic_steps(int iter);
    return (iter < 32) ? iter : 32;
  endfunction

  // cycles from input register to tangent output register
  function automatic int tan_latency(int iter);
    return cordic_steps(iter) + QuoBits + 5;
  endfunction

endpackage

// ===== rtl/sasd_tan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_tan
// Pipelined tangent: saturate, scale to radians, one CORDIC step per stage,
// one quotient bit per divider stage, sign restore. Result Q30.
// ----------------------------------------------------------------------------
module sasd_tan import sasd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef,
  parameter int TAN_ITERATIONS  = TanIterationsDef
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AngleW-1:0] angle,
  output logic signed [TanW-1:0]   tan_q30
);

  localparam int N  = cordic_steps(TAN_ITERATIONS);
  localparam int XW = 34;
  localparam int ZW = 42;
  localparam int DW = 64;
  localparam int RW = DW + 2;
  localparam longint Lim = longint'(45) << ANGLE_FRAC_BITS;
  localparam logic [34:0] R   = deg2rad_q40();
  localparam logic [17:0] RHi = R[34:17];
  localparam logic [16:0] RLo = R[16:0];

  // saturate and take magnitude
  logic signed [63:0] a64, a_sat, a_mag;
  logic [AngleW-1:0]  mag0;
  logic               neg0;

  always_comb begin
    a64   = 64'(angle);
    a_sat = (a64 > Lim) ? Lim : ((a64 < -Lim) ? -Lim : a64);
    a_mag = (a_sat < 0) ? -a_sat : a_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= a_mag[AngleW-1:0];
      neg0 <= angle[AngleW-1];
    end
  end

  // radians: split constant product
  logic [40:0] p_hi;
  logic [39:0] p_lo;
  logic        neg1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi <= 41'(mag0) * 41'(RHi);
      p_lo <= 40'(mag0) * 40'(RLo);
      neg1 <= neg0;
    end
  end

  logic [63:0] z_sum;
  assign z_sum = {6'd0, p_hi, 17'd0} + 64'(p_lo) + (64'd1 << (ANGLE_FRAC_BITS - 1));

  logic signed [XW-1:0] xs [N+1];
  logic signed [XW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic                 ng [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= XW'(64'd1 << 30);
      ys[0] <= '0;
      zs[0] <= $signed(ZW'(z_sum >> ANGLE_FRAC_BITS));
      ng[0] <= neg1;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] A = $signed(ZW'(atan_q40(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - A;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + A;
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  // divider setup: (|y| << 30 + x/2) / x
  logic signed [XW-1:0] x_fix;
  logic [XW-1:0]        y_abs;
  assign x_fix = (xs[N] <= 0) ? XW'(1) : xs[N];
  assign y_abs = (ys[N] < 0) ? XW'(-ys[N]) : XW'(ys[N]);

  logic [DW-1:0]      rm [QuoBits+1];
  logic [QuoBits-1:0] qs [QuoBits+1];
  logic [XW-2:0]      dv [QuoBits+1];
  logic               sg [QuoBits+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= (DW'(y_abs) << 30) + DW'(x_fix[XW-1:1]);
      qs[0] <= '0;
      dv[0] <= x_fix[XW-2:0];
      sg[0] <= ng[N] ^ ys[N][XW-1];
    end
  end

  for (genvar j = 0; j < QuoBits; j++) begin : g_div
    localparam int B = QuoBits - 1 - j;
    logic [RW-1:0] diff;
    assign diff = RW'(rm[j]) - (RW'(dv[j]) << B);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[RW-1]) begin
          rm[j+1] <= diff[DW-1:0];
          qs[j+1] <= qs[j] | (QuoBits'(1) << B);
        end else begin
          rm[j+1] <= rm[j];
          qs[j+1] <= qs[j];
        end
        dv[j+1] <= dv[j];
        sg[j+1] <= sg[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tan_q30 <= sg[QuoBits] ? -$signed(TanW'(qs[QuoBits])) : $signed(TanW'(qs[QuoBits]));
    end
  end

endmodule

// ===== rtl/secondary_actuator_step_deltas.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secondary_actuator_step_deltas
// Step deltas for three secondary mirror actuators from target tilt and focus.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tilt angles theta and phi, piston focus
//   and the three current actuator positions. m_axis returns one item of three
//   signed 36-bit step deltas for every command, in order.
//   cfg_wen/cfg_wdata load the actuator scale (radius times steps per inch);
//   write it only while no command is in flight.
// Pipeline from accept to output valid: angle saturation and radian scaling,
//   one stage per CORDIC step, divider setup, one stage per quotient bit of
//   the Q30 tangent divider, sign restore, then four matrix stages and the
//   output register.
// Throughput: one item per cycle while the output is not stalled; every stage
//   is a register with its valid bit, no unit is shared between items.
// Reset: clears all valid bits and loads the scale with 102160.
// Stall: while m_axis holds a valid item and m_axis_tready is low the whole
//   pipeline holds, and s_axis_tready drops; empty slots fill as it moves on.
// ----------------------------------------------------------------------------
module secondary_actuator_step_deltas import sasd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef,
  parameter int TAN_ITERATIONS  = TanIterationsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [ScaleW-1:0] cfg_wdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tilt_theta[22:0], tilt_phi[45:23], focus_piston[77:46], pos_t[109:78],
  // pos_u[141:110], pos_v[173:142], zero fill to 176
  input  logic [175:0]      s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // delta_t[35:0], delta_u[71:36], delta_v[107:72], zero fill to 112
  output logic [111:0]      m_axis_tdata
);

  localparam int LT = tan_latency(TAN_ITERATIONS);
  localparam int DL = LT + 4;   // stages carrying the piston terms
  localparam int PW = StepW + 1;

  // scale register
  logic [ScaleW-1:0] scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= ScaleReset;
    end else if (cfg_wen) begin
      scale <= cfg_wdata;
    end
  end

  // global advance: hold everything while the output item waits
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [AngleW-1:0] tilt_theta, tilt_phi;
  logic signed [StepW-1:0]  focus_piston, pos_t, pos_u, pos_v;
  assign tilt_theta   = $signed(s_axis_tdata[22:0]);
  assign tilt_phi     = $signed(s_axis_tdata[45:23]);
  assign focus_piston = $signed(s_axis_tdata[77:46]);
  assign pos_t        = $signed(s_axis_tdata[109:78]);
  assign pos_u        = $signed(s_axis_tdata[141:110]);
  assign pos_v        = $signed(s_axis_tdata[173:142]);

  // tangent units
  logic signed [TanW-1:0] tt, tp;

  sasd_tan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS)) u_tan_theta (
    .clk(clk), .en(en), .angle(tilt_theta), .tan_q30(tt)
  );
  sasd_tan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS)) u_tan_phi (
    .clk(clk), .en(en), .angle(tilt_phi), .tan_q30(tp)
  );

  // valid bits and exact piston terms (focus minus position) ride alongside
  logic                 vld [DL+1];
  logic signed [PW-1:0] pt_d [DL];
  logic signed [PW-1:0] pu_d [DL];
  logic signed [PW-1:0] pv_d [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DL; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k <= DL; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_d[0] <= PW'(focus_piston) - PW'(pos_t);
      pu_d[0] <= PW'(focus_piston) - PW'(pos_u);
      pv_d[0] <= PW'(focus_piston) - PW'(pos_v);
      for (int k = 1; k < DL; k++) begin
        pt_d[k] <= pt_d[k-1];
        pu_d[k] <= pu_d[k-1];
        pv_d[k] <= pv_d[k-1];
      end
    end
  end

  // M1: 0.866025 * tan theta in Q50
  logic signed [53:0]     c_prod;
  logic signed [TanW-1:0] tp_m1;
  always_ff @(posedge clk) begin
    if (en) begin
      c_prod <= 54'(tt) * $signed({34'd0, K866Q20});
      tp_m1  <= tp;
    end
  end

  // M2: round to Q31, form the three tilt sums
  localparam int AW = 37;
  logic signed [53:0]   c_rnd;
  logic signed [AW-1:0] c31;
  logic signed [AW-1:0] a_t, a_u, a_v;
  assign c_rnd = (c_prod + 54'sd262144) >>> 19;
  assign c31   = AW'(c_rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      a_t <= c31 + AW'(tp_m1);
      a_u <= -(AW'(tp_m1) <<< 1);
      a_v <= AW'(tp_m1) - c31;
    end
  end

  // M3: times scale, split into low unsigned and high signed partial products
  logic signed [ScaleW:0] s_sg;
  assign s_sg = $signed({1'b0, scale});

  logic [37:0]        lo_t, lo_u, lo_v;
  logic signed [39:0] hi_t, hi_u, hi_v;
  always_ff @(posedge clk) begin
    if (en) begin
      lo_t <= 38'(scale) * 38'(a_t[17:0]);
      lo_u <= 38'(scale) * 38'(a_u[17:0]);
      lo_v <= 38'(scale) * 38'(a_v[17:0]);
      hi_t <= 40'(s_sg) * 40'($signed(a_t[AW-1:18]));
      hi_u <= 40'(s_sg) * 40'($signed(a_u[AW-1:18]));
      hi_v <= 40'(s_sg) * 40'($signed(a_v[AW-1:18]));
    end
  end

  // M4: join partial products, round Q31 to integer
  localparam int SW = 60;
  localparam int TW = 30;
  logic signed [SW-1:0] sum_t, sum_u, sum_v;
  assign sum_t = (SW'(hi_t) <<< 18) + $signed(SW'(lo_t)) + (SW'(1) <<< 30);
  assign sum_u = (SW'(hi_u) <<< 18) + $signed(SW'(lo_u)) + (SW'(1) <<< 30);
  assign sum_v = (SW'(hi_v) <<< 18) + $signed(SW'(lo_v)) + (SW'(1) <<< 30);

  logic signed [TW-1:0] r_t, r_u, r_v;
  always_ff @(posedge clk) begin
    if (en) begin
      r_t <= TW'(sum_t >>> 31);
      r_u <= TW'(sum_u >>> 31);
      r_v <= TW'(sum_v >>> 31);
    end
  end

  // M5: add piston terms into the output register
  logic signed [DeltaW-1:0] delta_t, delta_u, delta_v;
  always_ff @(posedge clk) begin
    if (en) begin
      delta_t <= DeltaW'(r_t) + DeltaW'(pt_d[DL-1]);
      delta_u <= DeltaW'(r_u) + DeltaW'(pu_d[DL-1]);
      delta_v <= DeltaW'(r_v) + DeltaW'(pv_d[DL-1]);
    end
  end

  assign m_axis_tvalid = vld[DL];
  assign m_axis_tdata  = {4'd0, delta_v, delta_u, delta_t};

  // an accepted item enters the valid line
  a_enter : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted item missing from pipeline");

  // stall freezes the valid line
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(m_axis_tvalid) && $stable(vld[0]))
    else $error("pipeline moved during stall");

  // empty slot ahead of the output gives no output item after advance
  a_bubble : assert property (@(posedge clk) disable iff (rst)
    en && !vld[DL-1] |=> !m_axis_tvalid)
    else $error("output item invented");

  // scale write lands
  a_cfg : assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> scale == $past(cfg_wdata))
    else $error("scale write lost");

endmodule

// ===== bench/secondary_actuator_step_deltas_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secondary_actuator_step_deltas_tb
// Drives tilt/focus/position items into the actuator step delta block, holds
// a local CORDIC-tangent and mount-matrix predictor, and compares each
// returned item field by field, under random idling, long output stalls and
// several actuator scale settings.
// ----------------------------------------------------------------------------
module secondary_actuator_step_deltas_tb;
  import sasd_pkg::*;

  localparam int AngleFrac  = 16;
  localparam int TanSteps   = 20;
  localparam int PipeCycles = 62;
  localparam int IdleLimit  = 20000;
  localparam int AngleLim   = 45 << AngleFrac;

  typedef struct packed {
    logic signed [DeltaW-1:0] dv;
    logic signed [DeltaW-1:0] du;
    logic signed [DeltaW-1:0] dt;
  } deltas_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [ScaleW-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tilt_theta, tilt_phi, focus_piston, pos_t, pos_u, pos_v from bit 0 up
  logic [175:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // delta_t, delta_u, delta_v from bit 0 up
  logic [111:0] m_axis_tdata;

  secondary_actuator_step_deltas u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  deltas_t     pending_deltas[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  logic [ScaleW-1:0] scale_q = ScaleReset;
  logic [40:0] atan_rom[32];
  longint deg2rad;
  bit rx_idle_on = 1'b1;
  bit rx_hold = 1'b0;
  bit tx_idle_on = 1'b1;

  // floor shift of a signed value
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint tan_q30(longint a);
    longint z, x, y, dx, dy, q;
    longint unsigned mag, num;
    bit neg;
    x = 64'sd1 << 30;
    y = 0;
    if (a > AngleLim) a = AngleLim;
    if (a < -AngleLim) a = -AngleLim;
    neg = a < 0;
    mag = neg ? -a : a;
    z = (mag * deg2rad + (64'd1 << (AngleFrac - 1))) >> AngleFrac;
    for (int i = 0; i < TanSteps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_rom[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_rom[i]);
      end
    end
    if (x <= 0) x = 1;
    num = longint'(y < 0 ? -y : y) << 30;
    q = (num + longint'(x) / 2) / longint'(x);
    if (y < 0) neg = ~neg;
    return neg ? -q : q;
  endfunction

  function automatic deltas_t predict_deltas(logic [175:0] d);
    longint th, ph, fo, pt, pu, pv, tt, tp, c31, s, half;
    deltas_t r;
    th = longint'($signed(d[22:0]));
    ph = longint'($signed(d[45:23]));
    fo = longint'($signed(d[77:46]));
    pt = longint'($signed(d[109:78]));
    pu = longint'($signed(d[141:110]));
    pv = longint'($signed(d[173:142]));
    s = longint'({1'b0, scale_q});
    half = 64'sd1 << 30;
    tt = tan_q30(th);
    tp = tan_q30(ph);
    c31 = floor_shr(tt * 908093 + (64'sd1 << 18), 19);
    r.dt = DeltaW'(floor_shr(s * (c31 + tp) + half, 31) + (fo - pt));
    r.du = DeltaW'(floor_shr(s * (-2 * tp) + half, 31) + (fo - pu));
    r.dv = DeltaW'(floor_shr(s * (tp - c31) + half, 31) + (fo - pv));
    return r;
  endfunction

  // Send one command item; record its expected deltas on acceptance.
  task automatic send_command(logic signed [22:0] th, logic signed [22:0] ph,
                              logic [31:0] fo, logic [31:0] pt,
                              logic [31:0] pu, logic [31:0] pv);
    int gap;
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {2'b00, pv, pu, pt, fo, ph, th};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_deltas.push_back(predict_deltas({2'b00, pv, pu, pt, fo, ph, th}));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pending_deltas.size() != 0) @(negedge clk);
    repeat (PipeCycles + 4) @(negedge clk);
  endtask

  task automatic write_scale(logic [ScaleW-1:0] v);
    drain_pipe();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    scale_q = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic signed [22:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 23'($urandom);
      1: return $urandom_range(0, 1) ? 23'sd2949120 : -23'sd2949120;
      default: return 23'($signed($urandom_range(0, 2 * AngleLim)) - AngleLim);
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_command(rand_angle(), rand_angle(), $urandom, $urandom, $urandom,
                   $urandom);
  endtask

  // Extremes of angles and step fields, saturation past 45 degrees.
  task automatic test_directed();
    send_command(0, 0, 0, 0, 0, 0);
    send_command(23'sd2949120, 23'sd2949120, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h80000000);
    send_command(-23'sd2949120, -23'sd2949120, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff);
    send_command(23'h3fffff, 23'h400000, 32'hffffffff, 32'h1, 32'h0, 32'hffffffff);
    send_command(23'h400000, 23'h3fffff, 32'h1, 32'hffffffff, 32'h7fffffff, 0);
    send_command(23'sd2949121, -23'sd2949121, 0, 0, 0, 0);
    send_command(23'sd65536, -23'sd65536, 32'd1000, 32'd10, 32'd20, 32'd30);
    send_command(23'sd1, -23'sd1, 0, 0, 0, 0);
    send_command(23'sd1966080, 23'sd983040, 0, 32'h55555555, 32'haaaaaaaa, 0);
  endtask

  // Hold the output side off so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end
      send_random(120);
    join
  endtask

  // Zero scale (no tilt contribution), full scale, scale one, a random scale, then the reset scale.
  task automatic test_scale_settings();
    write_scale('0);
    send_command(23'sd2949120, -23'sd2949120, 32'd5, 32'd1, 32'd2, 32'd3);
    send_random(100);
    write_scale(20'hfffff);
    send_command(23'sd2949120, 23'sd2949120, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h80000000);
    send_command(-23'sd2949120, -23'sd2949120, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff);
    send_random(150);
    write_scale(20'd1);
    send_random(100);
    write_scale(20'($urandom_range(1, 20'hfffff)));
    send_random(150);
    write_scale(ScaleReset);
  endtask

  task automatic test_random_quiet();
    send_random(400);
    drain_pipe();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(300);
  endtask

  // Output side ready with random idle bursts, plus the forced hold.
  always begin
    @(negedge clk);
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each returned item with the oldest expectation.
  always @(posedge clk) begin
    deltas_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[107:0];
      if (pending_deltas.size() == 0) begin
        $error("unexpected result item %h", got);
        fail_count++;
      end else begin
        want = pending_deltas.pop_front();
        if (got.dt !== want.dt) begin
          $error("delta_t expected %0d got %0d", want.dt, got.dt);
          fail_count++;
        end
        if (got.du !== want.du) begin
          $error("delta_u expected %0d got %0d", want.du, got.du);
          fail_count++;
        end
        if (got.dv !== want.dv) begin
          $error("delta_v expected %0d got %0d", want.dv, got.dv);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with nothing accepted.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) atan_rom[i] = atan_q40(i);
    deg2rad = longint'(deg2rad_q40());
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_scale_settings();
    test_random_quiet();
    drain_pipe();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
